### design/fit_pkg.sv
// fit_pkg: shared types, constants and the membership function of the
// two-input fuzzy inference block. No dependencies.
package fit_pkg;

   localparam int REGION_COUNT = 5;
   localparam int RULE_COUNT   = 25;
   localparam int WEIGHT_FLOOR = 1;
   localparam int LEVEL_COUNT  = 8;
   localparam int LEVEL_ZERO   = 4;

   // datapath widths
   localparam int SAMPLE_W   = 16;
   localparam int DEG_W      = 13;   // 0..4096
   localparam int LEVEL_W    = 16;
   localparam int PROD_W     = 30;
   localparam int DEN_W      = 17;   // up to 25*4096
   localparam int NUM_W      = 35;
   localparam int MAG_W      = 33;
   localparam int Q_W        = 16;
   localparam int DIV_STAGES = 16;
   localparam int GROUP      = 5;
   localparam int LATENCY    = 5 + DIV_STAGES + 1;

   // csr register indexes
   localparam logic [3:0] CSR_LAST = 4'd7;

   // trapezoid shape codes
   localparam logic [1:0] SHAPE_LEFT    = 2'd0;
   localparam logic [1:0] SHAPE_REGULAR = 2'd1;
   localparam logic [1:0] SHAPE_RIGHT   = 2'd2;

   localparam logic [1:0] X_SHAPE [REGION_COUNT] =
      '{SHAPE_LEFT, SHAPE_REGULAR, SHAPE_REGULAR, SHAPE_REGULAR, SHAPE_RIGHT};
   localparam int X_A [REGION_COUNT] = '{-6144, -6144, -4096, 0, 4096};
   localparam int X_B [REGION_COUNT] = '{-4096, -4096, 0, 2048, 6144};
   localparam int X_C [REGION_COUNT] = '{0, -2048, 0, 4096, 0};
   localparam int X_D [REGION_COUNT] = '{0, 0, 4096, 6144, 0};

   localparam logic [1:0] Y_SHAPE [REGION_COUNT] =
      '{SHAPE_LEFT, SHAPE_REGULAR, SHAPE_REGULAR, SHAPE_REGULAR, SHAPE_RIGHT};
   localparam int Y_A [REGION_COUNT] = '{-8192, -8192, -4096, 0, 6144};
   localparam int Y_B [REGION_COUNT] = '{-6144, -6144, -2048, 4096, 8192};
   localparam int Y_C [REGION_COUNT] = '{0, -4096, 2048, 6144, 0};
   localparam int Y_D [REGION_COUNT] = '{0, 0, 4096, 8192, 0};

   // level slot per rule: 0..3 negative, 4 zero, 5..8 positive
   localparam int CONSEQUENT [25] = '{
      3, 1, 2, 8, 7,
      3, 1, 0, 8, 6,
      0, 0, 4, 8, 8,
      2, 0, 8, 7, 5,
      1, 0, 6, 7, 5};

   localparam logic signed [LEVEL_W-1:0] LEVEL_RESET [LEVEL_COUNT] =
      '{-16'sd100, -16'sd90, -16'sd80, -16'sd60, 16'sd60, 16'sd80, 16'sd90, 16'sd100};

   typedef logic [DEG_W-1:0] degree_type;
   typedef logic signed [LEVEL_W-1:0] level_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x_sample;
      logic signed [SAMPLE_W-1:0] y_sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [Q_W-1:0] drive_value;
      logic                  no_rule_fired;
   } rsp_payload_type;

   // sums handed from the rule stage to the divider
   typedef struct packed {
      logic                    valid;
      logic signed [NUM_W-1:0] num;
      logic [DEN_W-1:0]        den;
   } sums_type;

   // membership degree in Q0.12; every slope spans 0.5 or 1.0
   function automatic degree_type membership(input logic signed [SAMPLE_W-1:0] x,
                                             input int a, input int b, input int c,
                                             input int d, input logic [1:0] shape);
      logic signed [17:0] xs, as, bs, cs, ds, diff, span;
      degree_type r;
      xs = 18'(x);
      as = 18'(a);
      bs = 18'(b);
      cs = 18'(c);
      ds = 18'(d);
      r = '0;
      diff = '0;
      span = '0;
      case (shape)
         SHAPE_LEFT: begin
            if (xs <= as) r = 13'd4096;
            else if (xs >= bs) r = '0;
            else begin
               diff = bs - xs;
               span = bs - as;
               r = (span == 18'sd2048) ? 13'(diff <<< 1) : 13'(diff);
            end
         end
         SHAPE_RIGHT: begin
            if (xs <= as) r = '0;
            else if (xs >= bs) r = 13'd4096;
            else begin
               diff = xs - as;
               span = bs - as;
               r = (span == 18'sd2048) ? 13'(diff <<< 1) : 13'(diff);
            end
         end
         default: begin
            if (xs <= as || xs >= ds) r = '0;
            else if (xs >= bs && xs <= cs) r = 13'd4096;
            else if (xs <= bs) begin
               diff = xs - as;
               span = bs - as;
               r = (span == 18'sd2048) ? 13'(diff <<< 1) : 13'(diff);
            end else begin
               diff = ds - xs;
               span = ds - cs;
               r = (span == 18'sd2048) ? 13'(diff <<< 1) : 13'(diff);
            end
         end
      endcase
      return r;
   endfunction

endpackage

### design/fuzzy_inference_two_input.sv
// fuzzy_inference_two_input: top level, level registers and pipeline.
// Depends on fit_pkg, fit_fuzzify, fit_rules, fit_divider.

// Takes one x/y sample pair per clock and returns each result in order,
// as a one-cycle rsp_valid strobe; the receiver cannot stall. busy stays
// low: the pipeline is one fuzzify stage, three rule and sum stages, a
// divider entry stage, sixteen one-bit divider stages and an output
// register. Level registers are written through the csr channel, which is
// always ready; write them only while no transaction is in flight.
module fuzzy_inference_two_input import fit_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [3:0]      csr_index,
   input  level_type       csr_data
);

   level_type  level_ff [LEVEL_COUNT];
   logic       fz_valid;
   degree_type mx [REGION_COUNT];
   degree_type my [REGION_COUNT];
   sums_type   sums;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   // level registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LEVEL_RESET;
      end else if (csr_valid && csr_index <= CSR_LAST) begin
         level_ff[csr_index[2:0]] <= csr_data;
      end
   end

   fit_fuzzify u_fuzzify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (fz_valid),
      .mx        (mx),
      .my        (my)
   );

   fit_rules u_rules (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fz_valid),
      .mx       (mx),
      .my       (my),
      .level    (level_ff),
      .sums     (sums)
   );

   fit_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .sums      (sums),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

### design/fit_fuzzify.sv
// fit_fuzzify: first pipeline stage, five membership degrees per input.
// Depends on fit_pkg.
module fit_fuzzify import fit_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  req_payload_type in_data,
   output logic            out_valid,
   output degree_type      mx [REGION_COUNT],
   output degree_type      my [REGION_COUNT]
);

   logic       valid_ff;
   degree_type mx_ff [REGION_COUNT];
   degree_type my_ff [REGION_COUNT];

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
   end

   // degree registers
   always_ff @(posedge clock) begin
      for (int r = 0; r < REGION_COUNT; r++) begin
         mx_ff[r] <= membership(in_data.x_sample, X_A[r], X_B[r], X_C[r], X_D[r], X_SHAPE[r]);
         my_ff[r] <= membership(in_data.y_sample, Y_A[r], Y_B[r], Y_C[r], Y_D[r], Y_SHAPE[r]);
      end
   end

   assign out_valid = valid_ff;
   assign mx = mx_ff;
   assign my = my_ff;

endmodule

### design/fit_rules.sv
// fit_rules: rule weights, weighted levels and the two sums over three stages.
// Depends on fit_pkg.
module fit_rules import fit_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  degree_type mx [REGION_COUNT],
   input  degree_type my [REGION_COUNT],
   input  level_type  level [LEVEL_COUNT],
   output sums_type   sums
);

   localparam int GROUPS = (RULE_COUNT + GROUP - 1) / GROUP;

   logic [2:0] valid_ff;
   degree_type w_ff [RULE_COUNT];
   logic signed [PROD_W-1:0] prod_ff [RULE_COUNT];
   logic signed [NUM_W-1:0] pnum_ff [GROUPS];
   logic [DEN_W-1:0] pden_ff [GROUPS];
   logic signed [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= {valid_ff[1:0], in_valid};
   end

   // weight and weighted level per rule
   always_ff @(posedge clock) begin
      for (int r = 0; r < RULE_COUNT; r++) begin
         automatic degree_type wx = mx[r % REGION_COUNT];
         automatic degree_type wy = my[(r / REGION_COUNT) % REGION_COUNT];
         automatic degree_type w = (wx < wy) ? wx : wy;
         automatic level_type lv = '0;
         if (CONSEQUENT[r] < LEVEL_ZERO) lv = level[CONSEQUENT[r]];
         else if (CONSEQUENT[r] > LEVEL_ZERO) lv = level[CONSEQUENT[r] - 1];
         w_ff[r] <= w;
         prod_ff[r] <= PROD_W'($signed({1'b0, w}) * lv);
      end
   end

   // partial sums over groups of rules
   always_ff @(posedge clock) begin
      for (int g = 0; g < GROUPS; g++) begin
         automatic logic signed [NUM_W-1:0] sn = '0;
         automatic logic [DEN_W-1:0] sd = '0;
         for (int k = 0; k < GROUP; k++) begin
            if (g * GROUP + k < RULE_COUNT) begin
               sn = sn + NUM_W'(prod_ff[g * GROUP + k]);
               sd = sd + DEN_W'(w_ff[g * GROUP + k]);
            end
         end
         pnum_ff[g] <= sn;
         pden_ff[g] <= sd;
      end
   end

   // totals
   always_ff @(posedge clock) begin
      automatic logic signed [NUM_W-1:0] tn = '0;
      automatic logic [DEN_W-1:0] td = '0;
      for (int g = 0; g < GROUPS; g++) begin
         tn = tn + pnum_ff[g];
         td = td + pden_ff[g];
      end
      num_ff <= tn;
      den_ff <= td;
   end

   assign sums.valid = valid_ff[2];
   assign sums.num = num_ff;
   assign sums.den = den_ff;

endmodule

### design/fit_divider.sv
// fit_divider: pipelined signed division, one quotient bit per stage, with
// the weight floor check. Depends on fit_pkg.
module fit_divider import fit_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  sums_type        sums,
   output logic            out_valid,
   output rsp_payload_type out_data
);

   logic [DIV_STAGES:0] valid_ff;
   logic [DIV_STAGES:0] sign_ff;
   logic [DIV_STAGES:0] flag_ff;
   logic [DEN_W-1:0] rem_ff [DIV_STAGES+1];
   logic [Q_W-1:0]   low_ff [DIV_STAGES+1];
   logic [Q_W-1:0]   q_ff   [DIV_STAGES+1];
   logic [DEN_W-1:0] den_ff [DIV_STAGES+1];
   logic             ovalid_ff;
   rsp_payload_type  odata_ff;
   logic [MAG_W-1:0] mag;

   assign mag = sums.num[NUM_W-1] ? MAG_W'(-sums.num) : MAG_W'(sums.num);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         valid_ff <= {valid_ff[DIV_STAGES-1:0], sums.valid};
         ovalid_ff <= valid_ff[DIV_STAGES];
      end
   end

   // entry: sign, magnitude split, floor check
   always_ff @(posedge clock) begin
      sign_ff[0] <= sums.num[NUM_W-1];
      flag_ff[0] <= (sums.den == '0) || ({15'd0, sums.den} < 32'(WEIGHT_FLOOR));
      rem_ff[0] <= mag[DEN_W+Q_W-1:Q_W];
      low_ff[0] <= mag[Q_W-1:0];
      q_ff[0] <= '0;
      den_ff[0] <= sums.den;
   end

   // restoring division stages
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      logic [DEN_W:0] trial;
      logic           ge;
      assign trial = {rem_ff[i], low_ff[i][Q_W-1]};
      assign ge = trial >= {1'b0, den_ff[i]};
      always_ff @(posedge clock) begin
         rem_ff[i+1] <= ge ? DEN_W'(trial - {1'b0, den_ff[i]}) : trial[DEN_W-1:0];
         low_ff[i+1] <= {low_ff[i][Q_W-2:0], 1'b0};
         q_ff[i+1] <= {q_ff[i][Q_W-2:0], ge};
         den_ff[i+1] <= den_ff[i];
         sign_ff[i+1] <= sign_ff[i];
         flag_ff[i+1] <= flag_ff[i];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (flag_ff[DIV_STAGES]) begin
         odata_ff.drive_value <= '0;
         odata_ff.no_rule_fired <= 1'b1;
      end else begin
         odata_ff.drive_value <= sign_ff[DIV_STAGES] ? -$signed(q_ff[DIV_STAGES])
                                                    : $signed(q_ff[DIV_STAGES]);
         odata_ff.no_rule_fired <= 1'b0;
      end
   end

   assign out_valid = ovalid_ff;
   assign out_data = odata_ff;

endmodule

### design/fit_checker.sv
// fit_checker: port-level assertions for the top level, bound to it.
// Depends on fit_pkg.
module fit_checker import fit_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input logic            rsp_valid,
   input rsp_payload_type rsp_data,
   input logic            csr_ready
);

   // a result only follows a start transaction by the pipeline latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without matching start transaction");

   // floor flag forces a zero drive
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.no_rule_fired) |-> (rsp_data.drive_value == '0))
      else $error("no_rule_fired with nonzero drive");

   // the pipeline never holds off a transaction
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy && csr_ready)
      else $error("block refused a transaction");

endmodule

bind fuzzy_inference_two_input fit_checker u_fit_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);

### bench/tb_fuzzy_inference_two_input.sv
// tb_fuzzy_inference_two_input: self-checking bench for the two-input fuzzy
// inference block. Depends on fit_pkg and the block's RTL.
module tb_fuzzy_inference_two_input;
   import fit_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // predictor of drive value and flag, plus queue of pending results
   class drive_scoreboard;
      int level_slot [9];
      rsp_payload_type pending [$];
      int errors;

      function new();
         for (int i = 0; i < 8; i++) level_slot[i < 4 ? i : i + 1] = LEVEL_RESET[i];
         level_slot[4] = 0;
         errors = 0;
      endfunction

      function void set_level(int idx, level_type v);
         if (idx < 8) level_slot[idx < 4 ? idx : idx + 1] = v;
      endfunction

      // trapezoid degree in Q0.12
      function int grade(int x, int a, int b, int c, int d, logic [1:0] shp);
         case (shp)
            SHAPE_LEFT: begin
               if (x <= a) return 4096;
               if (x >= b) return 0;
               return (b - x) * 4096 / (b - a);
            end
            SHAPE_RIGHT: begin
               if (x <= a) return 0;
               if (x >= b) return 4096;
               return (x - a) * 4096 / (b - a);
            end
            default: begin
               if (x <= a || x >= d) return 0;
               if (x >= b && x <= c) return 4096;
               if (x <= b) return (x - a) * 4096 / (b - a);
               return (d - x) * 4096 / (d - c);
            end
         endcase
      endfunction

      function void note_sample(req_payload_type s);
         int mx [5], my [5];
         longint num, den, w;
         rsp_payload_type e;
         num = 0;
         den = 0;
         for (int r = 0; r < 5; r++) begin
            mx[r] = grade(s.x_sample, X_A[r], X_B[r], X_C[r], X_D[r], X_SHAPE[r]);
            my[r] = grade(s.y_sample, Y_A[r], Y_B[r], Y_C[r], Y_D[r], Y_SHAPE[r]);
         end
         for (int r = 0; r < RULE_COUNT; r++) begin
            w = mx[r % 5] < my[r / 5] ? mx[r % 5] : my[r / 5];
            num += w * level_slot[CONSEQUENT[r]];
            den += w;
         end
         if (den == 0 || den < WEIGHT_FLOOR) begin
            e.drive_value = '0;
            e.no_rule_fired = 1'b1;
         end else begin
            e.drive_value = 16'(num / den);
            e.no_rule_fired = 1'b0;
         end
         pending.push_back(e);
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result drive=%0d flag=%0b", $realtime,
                     got.drive_value, got.no_rule_fired);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.drive_value !== e.drive_value) begin
            $display("%0t: drive_value expected %0d actual %0d", $realtime,
                     e.drive_value, got.drive_value);
            errors++;
         end
         if (got.no_rule_fired !== e.no_rule_fired) begin
            $display("%0t: no_rule_fired expected %0b actual %0b", $realtime,
                     e.no_rule_fired, got.no_rule_fired);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy, rsp_valid, csr_ready;
   logic csr_valid = 1'b0;
   logic [3:0] csr_index = '0;
   level_type csr_data = '0;
   req_payload_type req_data = '0;
   rsp_payload_type rsp_data;
   drive_scoreboard board = new();
   int calm_left = 0;

   fuzzy_inference_two_input dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // accepted transactions at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_sample(req_data);
         if (rsp_valid) board.check_result(rsp_data);
      end
   end

   // one sample transaction, with random idle gaps while calm_left is zero
   task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y);
      while (calm_left == 0 && $urandom_range(99) < 10) begin
         start <= 1'b0;
         @(negedge clock);
      end
      if (calm_left > 0) calm_left--;
      start <= 1'b1;
      req_data <= '{x_sample: x, y_sample: y};
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // drain the pipeline then write one level register
   task automatic write_level(int idx, level_type v);
      start <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= 4'(idx);
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_level(idx, v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random sample biased toward the active region and breakpoints
   task automatic send_random();
      int pick;
      logic signed [15:0] v [2];
      for (int k = 0; k < 2; k++) begin
         pick = $urandom_range(9);
         if (pick < 6) v[k] = 16'($signed($urandom_range(20000)) - 10000);
         else if (pick < 8) v[k] = 16'(($signed($urandom_range(16)) - 8) * 1024
                                     + $signed($urandom_range(2)) - 1);
         else v[k] = 16'($urandom);
      end
      send_sample(v[0], v[1]);
   endtask

   initial begin
      level_type ext [4];
      ext = '{16'sh7fff, -16'sh8000, 16'sd0, -16'sd1};
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes and breakpoints
      send_sample(16'sh7fff, 16'sh7fff);
      send_sample(-16'sh8000, -16'sh8000);
      send_sample(16'sh7fff, -16'sh8000);
      send_sample(16'sd0, 16'sd0);
      send_sample(-16'sd6144, -16'sd8192);
      send_sample(-16'sd4096, -16'sd6144);
      send_sample(-16'sd2048, -16'sd4096);
      send_sample(16'sd2048, 16'sd2048);
      send_sample(16'sd4096, 16'sd4096);
      send_sample(16'sd6144, 16'sd6144);
      send_sample(16'sd6144, 16'sd8192);
      send_sample(16'sd1, -16'sd1);
      send_sample(-16'sd1, 16'sd1);
      send_sample(16'sh5555, -16'sh5556);

      // extreme and random level settings, each phase with random samples
      for (int phase = 0; phase < 6; phase++) begin
         for (int i = 0; i < 8; i++) begin
            if (phase < 4) write_level(i, (phase < 2) ? ext[(i + phase) % 2]
                                                 : ext[(i + phase) % 4]);
            else write_level(i, level_type'($urandom));
         end
         if (phase == 5) write_level(9, 16'sh1234);
         send_sample(16'sd0, 16'sd0);
         send_sample(-16'sd3000, 16'sd5000);
         if (phase == 2) calm_left = 150;
         repeat (280) send_random();
      end
      start <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb_fuzzy_inference_two_input: clean");
      else
         $display("tb_fuzzy_inference_two_input: errors");
      $finish;
   end

   initial begin
      #400000;
      $display("tb_fuzzy_inference_two_input: errors");
      $finish;
   end
endmodule
